FILE: rtl/core/hsv2rgb_pkg.sv
// hsv2rgb_pkg: shared widths, constants and the per-channel weight select
// for the hsv to rgb pixel converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

	// input field widths
	localparam int HUE_W   = 16;
	localparam int UNIT_W  = 14;
	localparam int BYTE_W  = 8;

	// stream payload widths, padded to whole bytes
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 32;

	// pipeline depth of the converter
	localparam int STAGES = 6;

	// fixed point: s and v in 2^-12 units, chroma in 2^-24 units
	localparam int UNIT_ONE     = 4096;
	localparam int CLAMP_W      = 13;
	localparam int CHROMA_W     = 25;
	localparam int WEIGHT_W     = 10;
	localparam int SUM_W        = 34;
	localparam int SCALE_W      = 39;

	// hue geometry in 1/16 degree units
	localparam int SECTOR_UNITS = 960;
	localparam int TURN_UNITS   = 5760;
	localparam int HUE_OFFSET   = 6 * TURN_UNITS;
	localparam int HUE_U_W      = 17;
	localparam int QUOT_W       = 7;
	localparam int FRAC_W       = 10;
	localparam int SECTOR_W     = 3;

	// reciprocal of 15 for floor(w/15), exact for w below 1052
	localparam int RECIP15       = 2185;
	localparam int RECIP15_SHIFT = 15;
	// reciprocal of 6 for floor(q/6), exact for q below 71
	localparam int RECIP6        = 43;
	localparam int RECIP6_SHIFT  = 8;

	// hue sectors of 60 degrees
	localparam logic [SECTOR_W-1:0] SEC_RED_YEL   = 3'd0;
	localparam logic [SECTOR_W-1:0] SEC_YEL_GRN   = 3'd1;
	localparam logic [SECTOR_W-1:0] SEC_GRN_CYN   = 3'd2;
	localparam logic [SECTOR_W-1:0] SEC_CYN_BLU   = 3'd3;
	localparam logic [SECTOR_W-1:0] SEC_BLU_MAG   = 3'd4;
	localparam logic [SECTOR_W-1:0] SEC_MAG_RED   = 3'd5;

	typedef enum logic [1:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE
	} chan_t;

	// clamp a signed unit value to 0..4096
	function automatic logic [CLAMP_W-1:0] clamp_unit(logic signed [UNIT_W-1:0] x);
		logic [CLAMP_W-1:0] r;
		if (x < 0) begin
			r = '0;
		end else if (x > UNIT_W'(UNIT_ONE)) begin
			r = CLAMP_W'(UNIT_ONE);
		end else begin
			r = x[CLAMP_W-1:0];
		end
		return r;
	endfunction

	// weight of chroma in one channel: full for the max channel, the ramp
	// for the middle channel, zero for the min channel
	function automatic logic [WEIGHT_W-1:0] chan_weight(chan_t ch,
			logic [SECTOR_W-1:0] sector, logic [FRAC_W-1:0] frac);
		logic [WEIGHT_W-1:0] ramp;
		logic [WEIGHT_W-1:0] full;
		logic [WEIGHT_W-1:0] w;
		full = WEIGHT_W'(SECTOR_UNITS);
		ramp = sector[0] ? (full - frac) : frac;
		w = '0;
		case (ch)
			CH_RED: begin
				case (sector) inside
					SEC_RED_YEL, SEC_MAG_RED: w = full;
					SEC_YEL_GRN, SEC_BLU_MAG: w = ramp;
					default:                  w = '0;
				endcase
			end
			CH_GREEN: begin
				case (sector) inside
					SEC_YEL_GRN, SEC_GRN_CYN: w = full;
					SEC_RED_YEL, SEC_CYN_BLU: w = ramp;
					default:                  w = '0;
				endcase
			end
			CH_BLUE: begin
				case (sector) inside
					SEC_CYN_BLU, SEC_BLU_MAG: w = full;
					SEC_GRN_CYN, SEC_MAG_RED: w = ramp;
					default:                  w = '0;
				endcase
			end
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hsv2rgb_chan.sv
// hsv2rgb_chan: one color channel back end, chroma weighting, offset add
// and scaling to a rounded byte over three pipeline stages.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_chan
	import hsv2rgb_pkg::*;
(
	input  wire                   clk,
	input  wire                   en,
	input  wire [CHROMA_W-1:0]    chroma,
	input  wire [WEIGHT_W-1:0]    weight,
	input  wire [SUM_W-1:0]       offset,
	output logic [BYTE_W-1:0]     chan_byte
);

	logic [SUM_W-1:0]       prod_s4;
	logic [SUM_W-1:0]       sum_s5;
	logic [SUM_W-1:0]       prod_full;
	logic [SCALE_W-1:0]     scaled;
	logic [BYTE_W:0]        rounded;

	// chroma times sector weight, value stays below 2^34
	assign prod_full = SUM_W'(chroma) * SUM_W'(weight);

	// byte = (17*sum + 2^29) >> 30, i.e. sum*255/(960*2^24) rounded half up
	assign scaled  = (SCALE_W'(sum_s5) << 4) + SCALE_W'(sum_s5) + (SCALE_W'(1) << 29);
	assign rounded = scaled[SCALE_W-1:30];

	// pipeline registers
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4   <= prod_full;
			sum_s5    <= prod_s4 + offset;
			chan_byte <= rounded[BYTE_W] ? {BYTE_W{1'b1}} : rounded[BYTE_W-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/hsv_to_rgb_pixel_convert_unit.sv
// hsv_to_rgb_pixel_convert_unit: top level of the hsv to rgba pixel converter,
// hue wrap, sector split, chroma and offset front end, valid pipeline.
// Depends on hsv2rgb_pkg and hsv2rgb_chan.
//
// Usage:
//   s_axis carries one pixel per transaction: hue (signed, 1/16 degree),
//   sat and val (signed, 4096 = 1.0, clamped to 0..4096) and an alpha byte.
//   m_axis returns red, green, blue and the unchanged alpha byte.
//   The datapath is a six stage pipeline. One pixel is accepted every cycle
//   while no result waits on a stalled receiver; throughput is then one
//   transaction per clock.
//   All stages advance together; stage depth is set by the hue reciprocal
//   multiply, the v*s multiply and the per-channel 25x10 weighting multiply.
//   When the receiver holds m_axis_tready low with a result waiting, the
//   whole pipeline freezes and s_axis_tready drops, so nothing is lost or
//   repeated; empty stages do not stall the pipeline.
//   arst_n clears all stage valid bits asynchronously; m_axis_tvalid is low
//   out of reset and s_axis_tready is high.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_pixel_convert_unit
	import hsv2rgb_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     s_axis_tvalid,
	output logic                    s_axis_tready,
	// hue[15:0], sat[29:16], val[43:30], alpha[51:44], zero pad[55:52]
	input  wire [IN_DATA_W-1:0]     s_axis_tdata,
	output logic                    m_axis_tvalid,
	input  wire                     m_axis_tready,
	// red[7:0], green[15:8], blue[23:16], alpha_out[31:24]
	output logic [OUT_DATA_W-1:0]   m_axis_tdata
);

	logic                           en;
	logic [STAGES-1:0]              valid_q;

	logic signed [HUE_W-1:0]        hue;
	logic signed [UNIT_W-1:0]       sat;
	logic signed [UNIT_W-1:0]       val;
	logic [BYTE_W-1:0]              alpha;
	logic signed [HUE_U_W:0]        hue_sum;

	logic [HUE_U_W-1:0]             hue_u_s1;
	logic [CLAMP_W-1:0]             sat_s1;
	logic [CLAMP_W-1:0]             val_s1;
	logic [HUE_U_W-1:0]             hue_u_s2;
	logic [QUOT_W-1:0]              quot_s2;
	logic [CHROMA_W-1:0]            chroma_s2;
	logic [CLAMP_W-1:0]             val_s2;
	logic [FRAC_W-1:0]              frac_s3;
	logic [SECTOR_W-1:0]            sector_s3;
	logic [CHROMA_W-1:0]            chroma_s3;
	logic [CHROMA_W-1:0]            diff_s3;
	logic [SUM_W-1:0]               offset_s4;
	logic [BYTE_W-1:0]              alpha_s1, alpha_s2, alpha_s3, alpha_s4, alpha_s5, alpha_s6;

	logic [22:0]                    recip_prod;
	logic [HUE_U_W-1:0]             sector_base;
	logic [HUE_U_W-1:0]             frac_full;
	logic [11:0]                    quot6_prod;
	logic [QUOT_W-1:0]              quot_div6;
	logic [QUOT_W-1:0]              sector_full;
	logic [BYTE_W-1:0]              red, green, blue;

	// unpack input transaction
	assign hue   = s_axis_tdata[HUE_W-1:0];
	assign sat   = s_axis_tdata[HUE_W+UNIT_W-1:HUE_W];
	assign val   = s_axis_tdata[HUE_W+2*UNIT_W-1:HUE_W+UNIT_W];
	assign alpha = s_axis_tdata[HUE_W+2*UNIT_W+BYTE_W-1:HUE_W+2*UNIT_W];

	// pipeline advances unless a result waits on a stalled receiver
	assign en            = !valid_q[STAGES-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = valid_q[STAGES-1];
	assign m_axis_tdata  = {alpha_s6, blue, green, red};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[STAGES-2:0], s_axis_tvalid};
		end
	end

	// stage 1: shift hue positive by whole turns, clamp s and v
	assign hue_sum = (HUE_U_W+1)'(hue) + (HUE_U_W+1)'(HUE_OFFSET);

	always_ff @(posedge clk) begin
		if (en) begin
			hue_u_s1 <= hue_sum[HUE_U_W-1:0];
			sat_s1   <= clamp_unit(sat);
			val_s1   <= clamp_unit(val);
			alpha_s1 <= alpha;
		end
	end

	// stage 2: sector count floor(u/960) = floor((u>>6)/15), chroma v*s
	assign recip_prod = 23'(hue_u_s1[HUE_U_W-1:6]) * 23'(RECIP15);

	always_ff @(posedge clk) begin
		if (en) begin
			hue_u_s2  <= hue_u_s1;
			quot_s2   <= recip_prod[RECIP15_SHIFT+QUOT_W-1:RECIP15_SHIFT];
			chroma_s2 <= CHROMA_W'(sat_s1) * CHROMA_W'(val_s1);
			val_s2    <= val_s1;
			alpha_s2  <= alpha_s1;
		end
	end

	// stage 3: offset inside the sector, sector mod 6, v - c
	assign sector_base = (HUE_U_W'(quot_s2) << 10) - (HUE_U_W'(quot_s2) << 6);
	assign frac_full   = hue_u_s2 - sector_base;
	assign quot6_prod  = 12'(quot_s2) * 12'(RECIP6);
	assign quot_div6   = QUOT_W'(quot6_prod[11:RECIP6_SHIFT]);
	assign sector_full = quot_s2 - (quot_div6 << 2) - (quot_div6 << 1);

	always_ff @(posedge clk) begin
		if (en) begin
			frac_s3   <= frac_full[FRAC_W-1:0];
			sector_s3 <= sector_full[SECTOR_W-1:0];
			chroma_s3 <= chroma_s2;
			diff_s3   <= {val_s2, 12'b0} - chroma_s2;
			alpha_s3  <= alpha_s2;
		end
	end

	// stages 4 to 6: shared offset term (v-c)*960, alpha delay line
	always_ff @(posedge clk) begin
		if (en) begin
			offset_s4 <= (SUM_W'(diff_s3) << 10) - (SUM_W'(diff_s3) << 6);
			alpha_s4  <= alpha_s3;
			alpha_s5  <= alpha_s4;
			alpha_s6  <= alpha_s5;
		end
	end

	// per-channel weighting and scaling
	hsv2rgb_chan u_chan_red (
		.clk       (clk),
		.en        (en),
		.chroma    (chroma_s3),
		.weight    (chan_weight(CH_RED, sector_s3, frac_s3)),
		.offset    (offset_s4),
		.chan_byte (red)
	);

	hsv2rgb_chan u_chan_green (
		.clk       (clk),
		.en        (en),
		.chroma    (chroma_s3),
		.weight    (chan_weight(CH_GREEN, sector_s3, frac_s3)),
		.offset    (offset_s4),
		.chan_byte (green)
	);

	hsv2rgb_chan u_chan_blue (
		.clk       (clk),
		.en        (en),
		.chroma    (chroma_s3),
		.weight    (chan_weight(CH_BLUE, sector_s3, frac_s3)),
		.offset    (offset_s4),
		.chan_byte (blue)
	);

endmodule

`default_nettype wire
